// ----- hdl/lpf_pkg.sv -----
// Shared types and constants of the IPv6 longest-prefix forwarder.
package lpf_pkg;

  localparam int unsigned ADDR_W      = 128;
  localparam int unsigned HALF_W      = 64;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned HL_W        = 8;
  localparam int unsigned VERDICT_W   = 3;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam logic [LEN_W-1:0] MAX_PREFIX_LEN = 8'd128;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_HI = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_LO = 1'b1;

  localparam logic OP_ADD_ROUTE = 1'b0;
  localparam logic OP_FORWARD   = 1'b1;

  typedef enum logic [VERDICT_W-1:0] {
    VERD_FORWARD    = 3'd0,
    VERD_LOCAL      = 3'd1,
    VERD_HOP_DROP   = 3'd2,
    VERD_NO_ROUTE   = 3'd3,
    VERD_ADDED      = 3'd4,
    VERD_TABLE_FULL = 3'd5
  } verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_WAIT,
    ST_FINAL
  } state_e;

  // One stored route.
  typedef struct packed {
    logic [HALF_W-1:0] prefix_hi;
    logic [HALF_W-1:0] prefix_lo;
    logic [LEN_W-1:0]  len;
    logic [HALF_W-1:0] hop_hi;
    logic [HALF_W-1:0] hop_lo;
  } route_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     write_route;
    logic     clear_scan;
    logic     issue_rd;
    logic     load_result;
    verdict_e verdict;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_add;
    logic full;
    logic hl_zero;
    logic is_local;
    logic count_zero;
    logic last_idx;
    logic found;
  } stat_t;

endpackage

// ----- hdl/lpf_ctrl.sv -----
// Controller state machine that sequences each word through evaluation and, for a lookup that needs it, the table scan.
module lpf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lpf_pkg::stat_t stat_i,
  output lpf_pkg::cmd_t  cmd_o
);
  import lpf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.verdict = VERD_NO_ROUTE;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
        if (stat_i.is_add) begin
          cmd_o.load_result = 1'b1;
          if (stat_i.full) begin
            cmd_o.verdict = VERD_TABLE_FULL;
          end else begin
            cmd_o.write_route = 1'b1;
            cmd_o.verdict     = VERD_ADDED;
          end
        end else if (stat_i.hl_zero) begin
          cmd_o.load_result = 1'b1;
          cmd_o.verdict     = VERD_HOP_DROP;
        end else if (stat_i.is_local) begin
          cmd_o.load_result = 1'b1;
          cmd_o.verdict     = VERD_LOCAL;
        end else if (stat_i.count_zero) begin
          cmd_o.load_result = 1'b1;
          cmd_o.verdict     = VERD_NO_ROUTE;
        end else begin
          cmd_o.clear_scan = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue_rd = 1'b1;
        if (stat_i.last_idx) begin
          state_d = ST_WAIT;
        end
      end
      // The last entry read is compared during this cycle.
      ST_WAIT: begin
        state_d = ST_FINAL;
      end
      ST_FINAL: begin
        cmd_o.load_result = 1'b1;
        cmd_o.verdict     = stat_i.found ? VERD_FORWARD : VERD_NO_ROUTE;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/lpf_dpath.sv -----
// Datapath: word capture, configuration registers, route table and best-match tracking.
module lpf_dpath #(
  parameter int unsigned MAX_ROUTES = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lpf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [lpf_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 opcode_i,
  input  logic [lpf_pkg::HALF_W-1:0]           addr_hi_i,
  input  logic [lpf_pkg::HALF_W-1:0]           addr_lo_i,
  input  logic [lpf_pkg::LEN_W-1:0]            prefix_len_i,
  input  logic [lpf_pkg::HALF_W-1:0]           next_hop_hi_i,
  input  logic [lpf_pkg::HALF_W-1:0]           next_hop_lo_i,
  input  logic [lpf_pkg::HL_W-1:0]             hop_limit_i,
  input  lpf_pkg::cmd_t                        cmd_i,
  output lpf_pkg::stat_t                       stat_o,
  output logic                                 done_o,
  output logic [lpf_pkg::VERDICT_W-1:0]        verdict_o,
  output logic [lpf_pkg::HALF_W-1:0]           out_hop_hi_o,
  output logic [lpf_pkg::HALF_W-1:0]           out_hop_lo_o,
  output logic [lpf_pkg::HL_W-1:0]             new_hop_limit_o,
  output logic [lpf_pkg::LEN_W-1:0]            matched_len_o
);
  import lpf_pkg::*;

  localparam int unsigned IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ROUTES + 1);

  // Configuration registers.
  logic [HALF_W-1:0] loc_hi_q, loc_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_hi_q <= '0;
      loc_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOCAL_HI: loc_hi_q <= cfg_wdata_i;
        REG_LOCAL_LO: loc_lo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Captured word.
  logic              op_q;
  logic [HALF_W-1:0] addr_hi_q, addr_lo_q, nh_hi_q, nh_lo_q;
  logic [LEN_W-1:0]  plen_q;
  logic [HL_W-1:0]   hl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= opcode_i;
      addr_hi_q <= addr_hi_i;
      addr_lo_q <= addr_lo_i;
      plen_q    <= prefix_len_i;
      nh_hi_q   <= next_hop_hi_i;
      nh_lo_q   <= next_hop_lo_i;
      hl_q      <= hop_limit_i;
    end
  end

  // Route table with one write and one registered read port.
  route_t            mem [MAX_ROUTES];
  route_t            wr_route;
  route_t            rd_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  idx_q;
  logic              rd_valid_q;

  always_comb begin
    wr_route.prefix_hi = addr_hi_q;
    wr_route.prefix_lo = addr_lo_q;
    wr_route.len       = (plen_q > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : plen_q;
    wr_route.hop_hi    = nh_hi_q;
    wr_route.hop_lo    = nh_lo_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_route) begin
      mem[count_q[IDX_W-1:0]] <= wr_route;
    end
    if (cmd_i.issue_rd) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.issue_rd;
      if (cmd_i.write_route) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.clear_scan) begin
        idx_q <= '0;
      end else if (cmd_i.issue_rd) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  // Prefix compare of the entry just read; bit b counts when b + len >= 128.
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] diff;
  logic              match;

  always_comb begin
    for (int b = 0; b < ADDR_W; b++) begin
      mask[b] = ({1'b0, rd_q.len} + 9'(b)) >= 9'(ADDR_W);
    end
    diff  = {rd_q.prefix_hi, rd_q.prefix_lo} ^ {addr_hi_q, addr_lo_q};
    match = ((diff & mask) == '0);
  end

  logic              found_q;
  logic [LEN_W-1:0]  best_len_q;
  logic [HALF_W-1:0] best_hi_q, best_lo_q;
  logic              take;

  // A later entry of equal length replaces the current best.
  assign take = rd_valid_q && match && (!found_q || (rd_q.len >= best_len_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.clear_scan) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_len_q <= rd_q.len;
      best_hi_q  <= rd_q.hop_hi;
      best_lo_q  <= rd_q.hop_lo;
    end
  end

  // Status towards the controller.
  always_comb begin
    stat_o.is_add     = (op_q == OP_ADD_ROUTE);
    stat_o.full       = (count_q == CNT_W'(MAX_ROUTES));
    stat_o.hl_zero    = (hl_q == '0);
    stat_o.is_local   = (addr_hi_q == loc_hi_q) && (addr_lo_q == loc_lo_q);
    stat_o.count_zero = (count_q == '0);
    stat_o.last_idx   = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
    stat_o.found      = found_q;
  end

  // Result registers.
  logic              done_q;
  logic [VERDICT_W-1:0] verdict_q;
  logic [HALF_W-1:0] ohi_q, olo_q;
  logic [HL_W-1:0]   nhl_q;
  logic [LEN_W-1:0]  mlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.load_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      verdict_q <= cmd_i.verdict;
      if (cmd_i.verdict == VERD_FORWARD) begin
        ohi_q  <= best_hi_q;
        olo_q  <= best_lo_q;
        nhl_q  <= hl_q - HL_W'(1);
        mlen_q <= best_len_q;
      end else begin
        ohi_q  <= '0;
        olo_q  <= '0;
        nhl_q  <= hl_q;
        mlen_q <= '0;
      end
    end
  end

  assign done_o          = done_q;
  assign verdict_o       = verdict_q;
  assign out_hop_hi_o    = ohi_q;
  assign out_hop_lo_o    = olo_q;
  assign new_hop_limit_o = nhl_q;
  assign matched_len_o   = mlen_q;

endmodule

// ----- hdl/ipv6_longest_prefix_forwarder.sv -----
// A route add, a hop limit drop, a local delivery or a lookup in an empty table is settled in
// the evaluation state after capture; any other lookup scans the stored routes in turn, waits
// for the last read and gives its result in the final state. The table is read one entry a
// cycle through its single read port. A new word is taken only once the last one is finished.
// The result strobe lasts one cycle; a new start is taken in that same cycle.
// Reset is asynchronous and active low; it empties the table and clears the local address.
module ipv6_longest_prefix_forwarder #(
  parameter int unsigned MAX_ROUTES = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lpf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [lpf_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 opcode_i,
  input  logic [lpf_pkg::HALF_W-1:0]           addr_hi_i,
  input  logic [lpf_pkg::HALF_W-1:0]           addr_lo_i,
  input  logic [lpf_pkg::LEN_W-1:0]            prefix_len_i,
  input  logic [lpf_pkg::HALF_W-1:0]           next_hop_hi_i,
  input  logic [lpf_pkg::HALF_W-1:0]           next_hop_lo_i,
  input  logic [lpf_pkg::HL_W-1:0]             hop_limit_i,
  output logic                                 done_o,
  output logic [lpf_pkg::VERDICT_W-1:0]        verdict_o,
  output logic [lpf_pkg::HALF_W-1:0]           out_hop_hi_o,
  output logic [lpf_pkg::HALF_W-1:0]           out_hop_lo_o,
  output logic [lpf_pkg::HL_W-1:0]             new_hop_limit_o,
  output logic [lpf_pkg::LEN_W-1:0]            matched_len_o
);
  import lpf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lpf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lpf_dpath #(
    .MAX_ROUTES (MAX_ROUTES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .addr_hi_i       (addr_hi_i),
    .addr_lo_i       (addr_lo_i),
    .prefix_len_i    (prefix_len_i),
    .next_hop_hi_i   (next_hop_hi_i),
    .next_hop_lo_i   (next_hop_lo_i),
    .hop_limit_i     (hop_limit_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .done_o          (done_o),
    .verdict_o       (verdict_o),
    .out_hop_hi_o    (out_hop_hi_o),
    .out_hop_lo_o    (out_hop_lo_o),
    .new_hop_limit_o (new_hop_limit_o),
    .matched_len_o   (matched_len_o)
  );

endmodule

// ----- hdl/lpf_checker.sv -----
// Port-level checks of the forwarder, bound to the top level.
module lpf_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 done_o,
  input logic [lpf_pkg::VERDICT_W-1:0]        verdict_o,
  input logic [lpf_pkg::HALF_W-1:0]           out_hop_hi_o,
  input logic [lpf_pkg::HALF_W-1:0]           out_hop_lo_o,
  input logic [lpf_pkg::HL_W-1:0]             new_hop_limit_o,
  input logic [lpf_pkg::LEN_W-1:0]            matched_len_o
);
  import lpf_pkg::*;

  // An accepted word keeps the block occupied in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after accepting a word");

  // A result word appears only once the block has gone idle, and never twice in a row.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy ##1 !done_o)
    else $error("result strobe while busy or repeated");

  // A forwarded packet had a non-zero hop limit and a prefix of at most 128 bits.
  a_forward_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (verdict_o == VERD_FORWARD) |->
      (new_hop_limit_o != 8'hFF) && (matched_len_o <= MAX_PREFIX_LEN))
    else $error("forwarded word has impossible hop limit or length");

  // Any other verdict carries no next hop and no matched length.
  a_other_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (verdict_o != VERD_FORWARD) |->
      (out_hop_hi_o == '0) && (out_hop_lo_o == '0) && (matched_len_o == '0))
    else $error("non-forward word carries route data");

endmodule

bind ipv6_longest_prefix_forwarder lpf_checker u_lpf_checker (.*);
